/* rtl/core/pstb_pkg.sv */
// ----------------------------------------------------------------------------
// pstb_pkg: shared types and constants of the periodic soft timer bank
// Command codes, the command and result word layouts and default sizes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pstb_pkg;

    // Default sizes handed to the top level parameters.
    localparam int NUM_SLOTS_DEF   = 15;
    localparam int COUNT_WIDTH_DEF = 32;

    // Number of slots that have a bit in the fire mask.
    localparam int FIRE_BITS = 15;

    // Command codes.
    localparam logic [2:0] CMD_TICK   = 3'd0;
    localparam logic [2:0] CMD_CREATE = 3'd1;
    localparam logic [2:0] CMD_DELETE = 3'd2;
    localparam logic [2:0] CMD_START  = 3'd3;
    localparam logic [2:0] CMD_STOP   = 3'd4;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [3:0]  slot;
        logic [31:0] period;
    } cmd_word_t;

    typedef struct packed {
        logic [FIRE_BITS-1:0] fire_mask;
        logic                 accepted;
    } result_word_t;

    // Per-slot outcome reported by the update unit.
    typedef struct packed {
        logic fire;
        logic ok;
    } slot_status_t;

endpackage

/* rtl/core/pstb_cell.sv */
// ----------------------------------------------------------------------------
// pstb_cell: one timer slot record in the rotating chain
// Holds the flags, counter and period of one slot and takes its neighbor's
// record whenever the chain advances.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pstb_cell #(
    parameter int COUNT_WIDTH = pstb_pkg::COUNT_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   shift,
    input  logic                   active_in,
    input  logic                   running_in,
    input  logic [COUNT_WIDTH-1:0] count_in,
    input  logic [COUNT_WIDTH-1:0] period_in,
    output logic                   active,
    output logic                   running,
    output logic [COUNT_WIDTH-1:0] count,
    output logic [COUNT_WIDTH-1:0] period
);

    logic                   active_reg;
    logic                   running_reg;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] period_reg;

    // The flags are control state; counter and period are always rewritten
    // by create before an active slot uses them.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= 1'b0;
            running_reg <= 1'b0;
        end
        else if (shift)
        begin
            active_reg  <= active_in;
            running_reg <= running_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            count_reg  <= count_in;
            period_reg <= period_in;
        end
    end

    assign active  = active_reg;
    assign running = running_reg;
    assign count   = count_reg;
    assign period  = period_reg;

endmodule

/* rtl/core/pstb_proc.sv */
// ----------------------------------------------------------------------------
// pstb_proc: slot update unit at the head of the chain
// Applies the current command to the one slot record passing the head and
// reports whether that slot fired and whether the command took effect.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pstb_proc #(
    parameter int COUNT_WIDTH = pstb_pkg::COUNT_WIDTH_DEF,
    parameter int IDX_W       = 4
) (
    input  pstb_pkg::cmd_word_t    cmd_word,
    input  logic [IDX_W-1:0]       idx,
    input  logic                   active,
    input  logic                   running,
    input  logic [COUNT_WIDTH-1:0] count,
    input  logic [COUNT_WIDTH-1:0] period,
    output logic                   active_out,
    output logic                   running_out,
    output logic [COUNT_WIDTH-1:0] count_out,
    output logic [COUNT_WIDTH-1:0] period_out,
    output pstb_pkg::slot_status_t status
);

    logic [COUNT_WIDTH-1:0] count_inc;
    logic                   hit;

    assign count_inc = count + COUNT_WIDTH'(1);
    assign hit       = (32'(cmd_word.slot) == 32'(idx));

    always_comb
    begin
        active_out  = active;
        running_out = running;
        count_out   = count;
        period_out  = period;
        status      = '0;
        case (cmd_word.cmd)
            pstb_pkg::CMD_TICK:
            begin
                status.ok = 1'b1;
                if (active && running)
                begin
                    if (count_inc >= period)
                    begin
                        count_out   = '0;
                        status.fire = 1'b1;
                    end
                    else
                    begin
                        count_out = count_inc;
                    end
                end
            end
            pstb_pkg::CMD_CREATE:
            begin
                if (hit && !active)
                begin
                    active_out  = 1'b1;
                    running_out = 1'b0;
                    count_out   = '0;
                    period_out  = COUNT_WIDTH'(cmd_word.period);
                    status.ok   = 1'b1;
                end
            end
            pstb_pkg::CMD_DELETE:
            begin
                if (hit && active)
                begin
                    active_out  = 1'b0;
                    running_out = 1'b0;
                    count_out   = '0;
                    period_out  = '0;
                    status.ok   = 1'b1;
                end
            end
            pstb_pkg::CMD_START, pstb_pkg::CMD_STOP:
            begin
                if (hit && active && (period != '0))
                begin
                    running_out = (cmd_word.cmd == pstb_pkg::CMD_START);
                    count_out   = '0;
                    status.ok   = 1'b1;
                end
            end
            default:
            begin
                status = '0;
            end
        endcase
    end

endmodule

/* rtl/core/periodic_soft_timer_bank.sv */
// ----------------------------------------------------------------------------
// periodic_soft_timer_bank: bank of periodic timer slots
// A command word is taken into a register, then walks every slot in turn:
// the slot records sit in a ring of NUM_SLOTS cells that advances one
// position per cycle unless held at its last slot, and a single update
// unit at the head of the ring handles one slot per cycle while the ring
// moves, so the ring length sets the time per command word.
// A new command word is stalled while a walk is in progress. A finished
// result word is held in an output register; if it has not been taken when
// the next walk reaches its last slot, the ring pauses there until the
// register frees up. A tick counts up every active running slot and reports
// in fire_mask the slots whose count reached their period; create, delete,
// start and stop act on the addressed slot only and report in accepted
// whether they took effect. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module periodic_soft_timer_bank #(
    parameter int NUM_SLOTS   = pstb_pkg::NUM_SLOTS_DEF,
    parameter int COUNT_WIDTH = pstb_pkg::COUNT_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cmd_valid,
    output logic                   cmd_stall,
    input  pstb_pkg::cmd_word_t    cmd_word,
    output logic                   result_valid,
    input  logic                   result_stall,
    output pstb_pkg::result_word_t result_word
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

    // Control state of the walk over the ring.
    logic                   busy_reg;
    logic                   busy_next;
    logic [IDX_W-1:0]       step_reg;
    logic [IDX_W-1:0]       step_next;
    pstb_pkg::cmd_word_t    cmd_reg;
    logic [pstb_pkg::FIRE_BITS-1:0] mask_reg;
    logic [pstb_pkg::FIRE_BITS-1:0] mask_next;
    logic                   ok_reg;
    logic                   ok_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    pstb_pkg::result_word_t out_word_reg;

    logic accept;
    logic last;
    logic shift;
    logic finish;

    // Outputs of each cell in the ring.
    logic                   cell_active  [NUM_SLOTS];
    logic                   cell_running [NUM_SLOTS];
    logic [COUNT_WIDTH-1:0] cell_count   [NUM_SLOTS];
    logic [COUNT_WIDTH-1:0] cell_period  [NUM_SLOTS];

    // Updated record leaving the head unit, fed into the tail cell.
    logic                   upd_active;
    logic                   upd_running;
    logic [COUNT_WIDTH-1:0] upd_count;
    logic [COUNT_WIDTH-1:0] upd_period;
    pstb_pkg::slot_status_t upd_status;

    assign accept = cmd_valid && !cmd_stall;
    assign last   = (step_reg == LAST_IDX);

    // The ring holds at its last slot while the previous result still waits.
    assign shift  = busy_reg && !(last && out_valid_reg && result_stall);
    assign finish = shift && last;

    assign cmd_stall    = busy_reg;
    assign result_valid = out_valid_reg;
    assign result_word  = out_word_reg;

    // Cell k hands its record to cell k-1; the head (cell 0) goes through
    // the update unit into the tail. After NUM_SLOTS moves each slot is back
    // in its own cell, and during step k the head holds slot k.
    generate
        for (genvar i = 0; i < NUM_SLOTS; i++)
        begin : g_ring
            if (i == NUM_SLOTS - 1)
            begin : g_tail
                pstb_cell #(
                    .COUNT_WIDTH(COUNT_WIDTH)
                ) u_cell (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .shift     (shift),
                    .active_in (upd_active),
                    .running_in(upd_running),
                    .count_in  (upd_count),
                    .period_in (upd_period),
                    .active    (cell_active[i]),
                    .running   (cell_running[i]),
                    .count     (cell_count[i]),
                    .period    (cell_period[i])
                );
            end
            else
            begin : g_body
                pstb_cell #(
                    .COUNT_WIDTH(COUNT_WIDTH)
                ) u_cell (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .shift     (shift),
                    .active_in (cell_active[i+1]),
                    .running_in(cell_running[i+1]),
                    .count_in  (cell_count[i+1]),
                    .period_in (cell_period[i+1]),
                    .active    (cell_active[i]),
                    .running   (cell_running[i]),
                    .count     (cell_count[i]),
                    .period    (cell_period[i])
                );
            end
        end
    endgenerate

    pstb_proc #(
        .COUNT_WIDTH(COUNT_WIDTH),
        .IDX_W      (IDX_W)
    ) u_proc (
        .cmd_word   (cmd_reg),
        .idx        (step_reg),
        .active     (cell_active[0]),
        .running    (cell_running[0]),
        .count      (cell_count[0]),
        .period     (cell_period[0]),
        .active_out (upd_active),
        .running_out(upd_running),
        .count_out  (upd_count),
        .period_out (upd_period),
        .status     (upd_status)
    );

    always_comb
    begin
        busy_next      = busy_reg;
        step_next      = step_reg;
        mask_next      = mask_reg;
        ok_next        = ok_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (accept)
        begin
            busy_next = 1'b1;
            step_next = '0;
            mask_next = '0;
            ok_next   = 1'b0;
        end
        else if (shift)
        begin
            step_next = last ? '0 : step_reg + IDX_W'(1);
            ok_next   = ok_reg | upd_status.ok;
            // Only the low slots have a place in the fire mask.
            for (int b = 0; b < pstb_pkg::FIRE_BITS; b++)
            begin
                if (upd_status.fire && (32'(step_reg) == 32'(b)))
                begin
                    mask_next[b] = 1'b1;
                end
            end
            if (last)
            begin
                busy_next      = 1'b0;
                out_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mask_reg <= mask_next;
        ok_reg   <= ok_next;
        if (accept)
        begin
            cmd_reg <= cmd_word;
        end
        if (finish)
        begin
            out_word_reg.fire_mask <= mask_next;
            out_word_reg.accepted  <= ok_next;
        end
    end

    // The walk position never leaves the ring.
    a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (32'(step_reg) < 32'(NUM_SLOTS)))
        else $error("walk position beyond the last slot");

    // Between walks the position is back at the first slot.
    a_idle_at_head: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (step_reg == '0))
        else $error("idle with the ring not realigned");

    // A new result word appears only as the end of a walk.
    a_result_from_walk: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> ($past(busy_reg) && !busy_reg))
        else $error("result word without a completed walk");

endmodule

/* test/periodic_soft_timer_bank_test.sv */
// ----------------------------------------------------------------------------
// periodic_soft_timer_bank_test: self-checking bench for the timer slot bank
// Drives command words with random gaps, stalls the result side at random,
// predicts every result word and compares each one as it leaves the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module periodic_soft_timer_bank_test;

    import pstb_pkg::*;

    localparam int SLOTS       = NUM_SLOTS_DEF;
    localparam int COUNT_W     = COUNT_WIDTH_DEF;
    localparam int CYCLE_LIMIT = 600000;
    localparam int RANDOM_WORDS = 1520;
    localparam int MAX_IDLE    = 18;
    // Long hold-off on the result side, taken once, so the block fills up.
    localparam int BACKUP_CYCLES = 400;
    localparam int BACKUP_AT     = 700;
    // Quiet cycles after the last result.
    localparam int DRAIN_CYCLES  = 40;

    // Command codes the block does not define; they must be ignored.
    localparam logic [2:0] CMD_UNUSED_LO = CMD_STOP + 3'd1;
    localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

    // ------------------------------------------------------------------------
    // Scoreboard: keeps its own copy of every slot, works out the result word
    // of each accepted command word and holds the results still to come.
    // ------------------------------------------------------------------------
    class timer_bank_scoreboard;
        bit               slot_on[SLOTS];
        bit               slot_counting[SLOTS];
        bit [COUNT_W-1:0] slot_ticks[SLOTS];
        bit [COUNT_W-1:0] slot_limit[SLOTS];
        result_word_t     awaited[$];
        int               failures;

        function result_word_t apply_command(cmd_word_t w);
            result_word_t res;
            int           idx;
            res = '0;
            idx = int'(w.slot);
            if (w.cmd == CMD_TICK)
            begin
                res.accepted = 1'b1;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (slot_on[i] && slot_counting[i])
                    begin
                        slot_ticks[i] = slot_ticks[i] + 1'b1;
                        if (slot_ticks[i] >= slot_limit[i])
                        begin
                            slot_ticks[i] = '0;
                            if (i < FIRE_BITS)
                                res.fire_mask[i] = 1'b1;
                        end
                    end
                end
            end
            else if (idx < SLOTS)
            begin
                case (w.cmd)
                    CMD_CREATE:
                        if (!slot_on[idx])
                        begin
                            slot_ticks[idx]    = '0;
                            slot_limit[idx]    = COUNT_W'(w.period);
                            slot_on[idx]       = 1'b1;
                            slot_counting[idx] = 1'b0;
                            res.accepted       = 1'b1;
                        end
                    CMD_DELETE:
                        if (slot_on[idx])
                        begin
                            slot_ticks[idx]    = '0;
                            slot_limit[idx]    = '0;
                            slot_on[idx]       = 1'b0;
                            slot_counting[idx] = 1'b0;
                            res.accepted       = 1'b1;
                        end
                    CMD_START, CMD_STOP:
                        if (slot_on[idx] && slot_limit[idx] != '0)
                        begin
                            slot_ticks[idx]    = '0;
                            slot_counting[idx] = (w.cmd == CMD_START);
                            res.accepted       = 1'b1;
                        end
                    default: ;
                endcase
            end
            return res;
        endfunction

        function void note_command(cmd_word_t w);
            awaited.push_back(apply_command(w));
        endfunction

        function void check_result(result_word_t got);
            result_word_t want;
            if (awaited.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result word: fire_mask=%h accepted=%0d",
                             got.fire_mask, got.accepted);
            end
            else
            begin
                want = awaited.pop_front();
                if (got.fire_mask !== want.fire_mask ||
                    got.accepted !== want.accepted)
                begin
                    failures++;
                    if (failures <= 10)
                        $display({"result mismatch: expected fire_mask=%h accepted=%0d,",
                                  " got fire_mask=%h accepted=%0d"},
                                 want.fire_mask, want.accepted,
                                 got.fire_mask, got.accepted);
                end
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         cmd_valid;
    logic         cmd_stall;
    cmd_word_t    cmd_word;
    logic         result_valid;
    logic         result_stall;
    result_word_t result_word;

    timer_bank_scoreboard sb = new();

    int cycle_count = 0;
    int words_sent;
    int words_checked = 0;

    periodic_soft_timer_bank DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_stall    (cmd_stall),
        .cmd_word     (cmd_word),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_word  (result_word)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // The watchdog bounds the run well beyond the slowest legal schedule:
    // every word waiting out the longest sender gap, a full walk and the
    // longest receiver stall, plus the one long hold-off.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Both channels are sampled at the rising edge, before the block's own
    // registers move, so a word counts only where valid is high and stall
    // is low. Commands are noted first; a result never belongs to a command
    // accepted on the same edge, since the walk over the slots comes after it.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_valid && !cmd_stall)
                sb.note_command(cmd_word);
            if (result_valid && !result_stall)
            begin
                sb.check_result(result_word);
                words_checked <= words_checked + 1;
            end
        end
    end

    // Offers one command word. The gap before it is drawn per word, except
    // in every fourth stretch of 150 words, which runs back to back. Valid is
    // left high when the next word follows at once, so it is never lowered
    // and raised in the same step. Called and returns at a falling edge.
    task automatic send_word(input cmd_word_t w);
        int gap_cycles;
        gap_cycles = (((words_sent / 150) % 4) == 3) ? 0
                                                     : $urandom_range(0, MAX_IDLE);
        if (gap_cycles > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap_cycles) @(negedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_word  <= w;
        do
            @(posedge clk);
        while (cmd_stall);
        words_sent++;
        @(negedge clk);
    endtask

    task automatic send_fields(input logic [2:0] code, input logic [3:0] slot_no,
                               input logic [31:0] ticks);
        cmd_word_t w;
        w.cmd    = code;
        w.slot   = slot_no;
        w.period = ticks;
        send_word(w);
    endtask

    // Random command mix. Ticks dominate and most periods are short so that
    // slots fire often; creates, deletes, starts and stops keep the slots
    // moving through all their states. A share of words use an out-of-range
    // slot or an unused code; those are ignored and not counted. Returns 1
    // when the word is one that the block acts on.
    task automatic send_random_word(output bit counted);
        cmd_word_t w;
        int        pick;
        int        kind;
        pick     = $urandom_range(0, 99);
        w.slot   = 4'($urandom_range(0, SLOTS - 1));
        w.period = $urandom;
        counted  = 1'b1;
        if (pick < 45)
        begin
            w.cmd  = CMD_TICK;
            w.slot = 4'($urandom);
        end
        else if (pick < 60)
        begin
            w.cmd = CMD_CREATE;
            kind  = $urandom_range(0, 19);
            if (kind < 17)
                w.period = $urandom_range(1, 12);
            else if (kind < 19)
                w.period = '0;
        end
        else if (pick < 68)
        begin
            w.cmd = CMD_DELETE;
        end
        else if (pick < 80)
        begin
            w.cmd = CMD_START;
        end
        else if (pick < 88)
        begin
            w.cmd = CMD_STOP;
        end
        else if (pick < 94)
        begin
            w.cmd   = 3'($urandom_range(CMD_CREATE, CMD_STOP));
            w.slot  = 4'($urandom_range(SLOTS, 15));
            counted = 1'b0;
        end
        else
        begin
            w.cmd   = 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
            w.slot  = 4'($urandom);
            counted = 1'b0;
        end
        send_word(w);
    endtask

    // Result side. Before each word the receiver holds stall high for a
    // drawn number of cycles; every fourth stretch of 150 results runs with
    // no stall at all. Once, the hold-off is long while the sender keeps
    // offering words, which backs the block up until it stalls its input.
    initial
    begin
        int  hold_cycles;
        bit  backed_up;
        backed_up = 1'b0;
        result_stall = 1'b1;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (!backed_up && words_checked >= BACKUP_AT)
            begin
                hold_cycles = BACKUP_CYCLES;
                backed_up   = 1'b1;
            end
            else if (((words_checked / 150) % 4) == 1)
            begin
                hold_cycles = 0;
            end
            else
            begin
                hold_cycles = $urandom_range(0, MAX_IDLE);
            end
            if (hold_cycles > 0)
            begin
                result_stall <= 1'b1;
                repeat (hold_cycles) @(negedge clk);
            end
            result_stall <= 1'b0;
            do
                @(posedge clk);
            while (!result_valid);
            @(negedge clk);
        end
    end

    // Stimulus: reset, a directed walk through the corner cases, then the
    // random mix, then a drain and the verdict.
    initial
    begin
        bit counted;
        int random_count;
        words_sent    = 0;
        random_count  = 0;
        rst_n     = 1'b0;
        cmd_valid = 1'b0;
        cmd_word  = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // A tick with nothing active still counts as accepted.
        send_fields(CMD_TICK, 4'd0, 32'd0);
        // Create, then a second create on the same slot, which is refused.
        send_fields(CMD_CREATE, 4'd0, 32'd1);
        send_fields(CMD_CREATE, 4'd0, 32'd5);
        send_fields(CMD_START, 4'd0, 32'hFFFF_FFFF);
        send_fields(CMD_TICK, 4'd0, 32'hFFFF_FFFF);
        // Starting a running slot is accepted and restarts its count.
        send_fields(CMD_START, 4'd0, 32'd0);
        // The highest slot owns the top bit of the fire mask.
        send_fields(CMD_CREATE, 4'(SLOTS - 1), 32'd2);
        send_fields(CMD_START, 4'(SLOTS - 1), 32'd0);
        send_fields(CMD_TICK, 4'hF, 32'd0);
        send_fields(CMD_TICK, 4'hF, 32'd0);
        // Stopping a stopped slot is accepted too.
        send_fields(CMD_STOP, 4'd0, 32'd0);
        send_fields(CMD_STOP, 4'd0, 32'd0);
        // A slot with period zero can neither start nor stop.
        send_fields(CMD_CREATE, 4'd3, 32'd0);
        send_fields(CMD_START, 4'd3, 32'd0);
        send_fields(CMD_STOP, 4'd3, 32'd0);
        // Delete, start and stop on an inactive slot are refused.
        send_fields(CMD_DELETE, 4'd5, 32'd0);
        send_fields(CMD_START, 4'd5, 32'd0);
        send_fields(CMD_STOP, 4'd5, 32'd0);
        // The largest period: counts but does not fire within this run.
        send_fields(CMD_CREATE, 4'd7, 32'hFFFF_FFFF);
        send_fields(CMD_START, 4'd7, 32'd0);
        // A slot number past the bank and the unused codes are ignored.
        send_fields(CMD_CREATE, 4'(SLOTS), 32'd1);
        send_fields(CMD_UNUSED_LO, 4'hF, 32'hFFFF_FFFF);
        send_fields(CMD_UNUSED_LO + 3'd1, 4'd0, 32'd1);
        send_fields(CMD_UNUSED_HI, 4'd1, 32'd1);
        send_fields(CMD_DELETE, 4'd0, 32'd0);

        while (random_count < RANDOM_WORDS)
        begin
            send_random_word(counted);
            if (counted)
                random_count++;
        end
        cmd_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.pending() != 0)
        begin
            sb.failures += sb.pending();
            $display("%0d result words never arrived", sb.pending());
        end
        if (sb.failures == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
